// ===== design/obpc_pkg.sv =====
// shared types, codes and constants of the optical bubble pulse counter
package obpc_pkg;

  // history entry status codes
  localparam logic [1:0] ST_PERIOD = 2'd0;
  localparam logic [1:0] ST_LONG   = 2'd1;
  localparam logic [1:0] ST_SMALL  = 2'd2;
  localparam logic [1:0] ST_STALL  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLE        = 3'd0;
  localparam logic [2:0] CFG_CHANGE_LEVEL  = 3'd1;
  localparam logic [2:0] CFG_CHANGE_TIME   = 3'd2;
  localparam logic [2:0] CFG_MAX_BUBBLE_MS = 3'd3;
  localparam logic [2:0] CFG_MIN_BUBBLE_LV = 3'd4;
  localparam logic [2:0] CFG_MINMAX_PERIOD = 3'd5;

  // event flag bit positions
  localparam int FL_MINMAX    = 0;
  localparam int FL_SECOND    = 1;
  localparam int FL_LIGHT_ON  = 2;
  localparam int FL_LIGHT_OFF = 3;
  localparam int FL_LOGGED    = 4;

  localparam logic [7:0]  LEVEL_OFFSET   = 8'd125;
  localparam logic [31:0] STALL_MS       = 32'd10000;
  localparam logic [31:0] SECOND_MS      = 32'd1000;
  localparam logic [15:0] TOL_KNEE       = 16'd5000;
  localparam logic [7:0]  BYTE_MAX       = 8'd255;
  localparam logic [9:0]  LEVEL_MAX      = 10'd1023;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [9:0]  level;
  } sample_t;

  typedef struct packed {
    logic [4:0]  event_flags;
    logic [31:0] bubble_count;
    logic [1:0]  period_status;
    logic [15:0] period_ms;
    logic        regular;
    logic [9:0]  min_seen;
    logic [9:0]  max_seen;
    logic [15:0] bubble_ms;
    logic [15:0] gap_ms;
    logic [15:0] samples_per_sec;
    logic [15:0] window_errors_per_sec;
    logic [15:0] overflow_errors_per_sec;
  } result_t;

  // one log request toward the history
  typedef struct packed {
    logic        en;
    logic [1:0]  status;
    logic [15:0] period;
  } hist_log_t;

  // what the history reports back
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] period;
    logic        regular;
    logic        busy;
  } hist_view_t;

  // stored level byte back to a signed level step
  function automatic logic signed [9:0] level_delta(input logic [7:0] b);
    level_delta = $signed({2'b00, b}) - $signed({2'b00, LEVEL_OFFSET});
  endfunction

  function automatic logic [15:0] inc16(input logic [15:0] v);
    inc16 = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v > 32'h0000_FFFF) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== design/obpc_sample_if.sv =====
// sample channel: valid, ready and one timestamped light sample
interface obpc_sample_if;
  logic              valid;
  logic              ready;
  obpc_pkg::sample_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/obpc_result_if.sv =====
// result channel: valid, ready and one result record
interface obpc_result_if;
  logic              valid;
  logic              ready;
  obpc_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/obpc_ram.sv =====
// generic single write port ram with registered read
module obpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/obpc_history.sv =====
// bubble duration history with newest entry and regularity scan
module obpc_history #(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  obpc_pkg::hist_log_t   log_req,
  input  logic                  scan_start,
  output obpc_pkg::hist_view_t  view
);
  localparam int HI_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  logic [HI_W-1:0]          idx;
  logic [HI_W-1:0]          idx_next;
  logic [HISTORY_DEPTH-1:0] valid_bits;
  logic [1:0]               newest_status;
  logic [15:0]              newest_period;
  logic                     regular;
  logic                     scan_on;
  logic [HI_W-1:0]          scan_cnt;
  logic                     pend;
  logic                     pend_last;
  logic                     pend_vb;
  logic                     acc_stall;
  logic                     acc_period;
  logic [15:0]              lo;
  logic [15:0]              hi;
  logic [17:0]              rdata;
  logic [1:0]               e_status;
  logic [15:0]              e_period;
  logic                     acc_stall_next;
  logic                     acc_period_next;
  logic [15:0]              lo_next;
  logic [15:0]              hi_next;
  logic [16:0]              lo_tol;

  assign idx_next = (idx == HI_W'(HISTORY_DEPTH - 1)) ? '0 : idx + HI_W'(1);

  obpc_ram #(.WIDTH(18), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (log_req.en),
    .waddr (idx_next),
    .wdata ({log_req.status, log_req.period}),
    .raddr (scan_cnt),
    .rdata (rdata)
  );

  // an entry never written reads as too long with no period
  always_comb begin
    e_status        = pend_vb ? rdata[17:16] : obpc_pkg::ST_LONG;
    e_period        = pend_vb ? rdata[15:0] : 16'd0;
    acc_stall_next  = acc_stall & (e_status == obpc_pkg::ST_STALL);
    acc_period_next = acc_period & (e_status == obpc_pkg::ST_PERIOD);
    lo_next         = (e_period < lo) ? e_period : lo;
    hi_next         = (e_period > hi) ? e_period : hi;
    lo_tol          = {1'b0, lo_next} + ((lo_next > obpc_pkg::TOL_KNEE) ? 17'd20 : 17'd10);
  end

  // log writes and the scan over all entries
  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= '0;
      valid_bits    <= '0;
      newest_status <= obpc_pkg::ST_LONG;
      newest_period <= 16'd0;
      regular       <= 1'b0;
      scan_on       <= 1'b0;
      pend          <= 1'b0;
    end else begin
      if (log_req.en) begin
        idx                  <= idx_next;
        valid_bits[idx_next] <= 1'b1;
        newest_status        <= log_req.status;
        newest_period        <= log_req.period;
      end
      if (scan_start) begin
        scan_on    <= 1'b1;
        scan_cnt   <= '0;
        acc_stall  <= 1'b1;
        acc_period <= 1'b1;
        lo         <= 16'hFFFF;
        hi         <= 16'd0;
      end else if (scan_on) begin
        if (scan_cnt == HI_W'(HISTORY_DEPTH - 1)) begin
          scan_on <= 1'b0;
        end else begin
          scan_cnt <= scan_cnt + HI_W'(1);
        end
      end
      pend      <= scan_on;
      pend_last <= (scan_cnt == HI_W'(HISTORY_DEPTH - 1));
      pend_vb   <= valid_bits[scan_cnt];
      if (pend) begin
        acc_stall  <= acc_stall_next;
        acc_period <= acc_period_next;
        lo         <= lo_next;
        hi         <= hi_next;
        if (pend_last) begin
          regular <= acc_stall_next | (acc_period_next & (lo_tol > {1'b0, hi_next}));
        end
      end
    end
  end

  assign view = '{status: newest_status, period: newest_period, regular: regular,
                  busy: scan_on | pend};
endmodule

// ===== design/optical_bubble_pulse_counter.sv =====
// top level: sample sequencer, sliding window ring and bubble detector
//
//  channel  | dir | handshake    | payload
//  sample   | in  | valid/ready  | now_ms[31:0], level[9:0]
//  result   | out | valid/ready  | event_flags .. overflow_errors_per_sec
//  cfg      | in  | cfg_we only  | cfg_index[2:0], cfg_data[15:0]
//
// one sample at a time; an ignored one goes to S_DONE, a processed one
// to S_FRONT, S_SHRINK/S_SHRINK_RD per entry dropped, S_DETECT, S_ADV,
// S_OVF_RD on overflow, S_STALL, S_SECOND, S_SCAN_WAIT if the history was
// written (regularity scan); the trim uses a single registered-read port
// rst is synchronous; the ring needs no clearing, the history has valid bits
// a result waits in the output register; the next sample is taken meanwhile
module optical_bubble_pulse_counter #(
  parameter int WINDOW_DEPTH  = 64,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  obpc_sample_if.sink          sample,
  obpc_result_if.source        result,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  localparam int RW   = $clog2(WINDOW_DEPTH);
  localparam int WT_W = $clog2(WINDOW_DEPTH * 255 + 1);
  localparam int WL_W = WT_W + 1;
  localparam int RL_W = ((WL_W > 16) ? WL_W : 16) + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_FRONT, S_SHRINK, S_SHRINK_RD, S_DETECT, S_ADV, S_OVF_RD,
    S_STALL, S_SECOND, S_SCAN_WAIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_IDLE, PH_RISE, PH_FALL} phase_t;

  state_t state;
  phase_t phase;

  // configuration
  logic        enable;
  logic [9:0]  change_level;
  logic [7:0]  change_time;
  logic [7:0]  max_bubble_ms;
  logic [7:0]  min_bubble_level;
  logic [15:0] minmax_period;

  // sample and window state
  logic [31:0]             now_r;
  logic [9:0]              lvl_r;
  logic                    primed;
  logic [31:0]             prev_time;
  logic [9:0]              prev_level;
  logic [7:0]              dtb_r;
  logic [7:0]              dlb_r;
  logic [RW-1:0]           head;
  logic [RW-1:0]           tail;
  logic [RW-1:0]           head_next;
  logic [RW-1:0]           tail_next;
  logic [WT_W-1:0]         window_time;
  logic signed [WL_W-1:0]  window_level;
  logic [15:0]             run_ms;
  logic signed [RL_W-1:0]  run_lvl;
  logic signed [RL_W-1:0]  peak_lvl;
  logic [31:0]             run_gap;
  logic [31:0]             count;
  logic [31:0]             next_minmax;
  logic [31:0]             next_stall;
  logic [31:0]             next_second;
  logic [9:0]              run_min;
  logic [9:0]              run_max;
  logic [9:0]              rep_min;
  logic [9:0]              rep_max;
  logic [15:0]             rep_bubble;
  logic [15:0]             rep_gap;
  logic [15:0]             cnt_samples;
  logic [15:0]             cnt_werr;
  logic [15:0]             cnt_oerr;
  logic [15:0]             rep_samples;
  logic [15:0]             rep_werr;
  logic [15:0]             rep_oerr;
  logic [4:0]              flags;
  logic                    logged;
  logic                    out_valid;
  obpc_pkg::result_t       out_reg;

  // datapath temporaries
  logic [31:0]             dt;
  logic [7:0]              dtb;
  logic signed [11:0]      dl;
  logic [7:0]              dlb;
  logic [9:0]              mn_n;
  logic [9:0]              mx_n;
  logic [32:0]             gap_sum;
  logic [15:0]             ring_rdata;
  logic                    win_over;
  logic                    shrink_go;
  logic signed [RL_W-1:0]  wl_e;
  logic signed [RL_W-1:0]  cl_s;
  logic signed [RL_W-1:0]  mbl_s;
  logic [15:0]             rbm_n;
  logic signed [RL_W-1:0]  rbl_n;
  logic signed [RL_W-1:0]  peak_n;
  logic [31:0]             gap;
  logic [31:0]             per;
  logic                    det_rise;
  logic                    det_long;
  logic                    det_fall;
  logic                    det_settle;
  logic                    det_big;
  logic                    stall_due;
  logic                    scan_start;
  obpc_pkg::hist_log_t     hist_log;
  obpc_pkg::hist_view_t    hist_view;

  assign head_next = (head == RW'(WINDOW_DEPTH - 1)) ? '0 : head + RW'(1);
  assign tail_next = (tail == RW'(WINDOW_DEPTH - 1)) ? '0 : tail + RW'(1);

  obpc_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH)) u_ring (
    .clk   (clk),
    .we    (state == S_FRONT),
    .waddr (head),
    .wdata ({dtb, dlb}),
    .raddr (tail),
    .rdata (ring_rdata)
  );

  obpc_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_history (
    .clk        (clk),
    .rst        (rst),
    .log_req    (hist_log),
    .scan_start (scan_start),
    .view       (hist_view)
  );

  // sample deltas, clamped to a byte
  always_comb begin
    dt      = now_r - prev_time;
    dtb     = (dt > 32'(obpc_pkg::BYTE_MAX)) ? obpc_pkg::BYTE_MAX : dt[7:0];
    dl      = $signed({2'b00, lvl_r}) - $signed({2'b00, prev_level})
              + $signed({4'b0000, obpc_pkg::LEVEL_OFFSET});
    dlb     = (dl < 12'sd0) ? 8'd0 : ((dl > 12'sd255) ? obpc_pkg::BYTE_MAX : dl[7:0]);
    mn_n    = (lvl_r < run_min) ? lvl_r : run_min;
    mx_n    = (lvl_r > run_max) ? lvl_r : run_max;
    gap_sum = {1'b0, run_gap} + 33'(dtb);
  end

  assign win_over  = window_time > WT_W'(change_time);
  assign shrink_go = win_over && (tail != head);

  // bubble detector decisions
  always_comb begin
    wl_e       = RL_W'(window_level);
    cl_s       = $signed({{(RL_W-10){1'b0}}, change_level});
    mbl_s      = $signed({{(RL_W-8){1'b0}}, min_bubble_level});
    rbm_n      = run_ms + 16'(dtb_r);
    rbl_n      = run_lvl + RL_W'(obpc_pkg::level_delta(dlb_r));
    peak_n     = (rbl_n > peak_lvl) ? rbl_n : peak_lvl;
    gap        = (run_gap > 32'(rbm_n)) ? run_gap - 32'(rbm_n) : 32'd0;
    per        = (run_gap > 32'(rbm_n)) ? run_gap : 32'(rbm_n);
    det_rise   = (phase == PH_IDLE) && (wl_e > cl_s);
    det_long   = (phase != PH_IDLE) && (rbm_n > 16'(max_bubble_ms));
    det_fall   = (phase == PH_RISE) && !det_long && (wl_e < -cl_s);
    det_settle = (phase == PH_FALL) && !det_long && (wl_e >= -cl_s) && (wl_e <= cl_s);
    det_big    = peak_n > mbl_s;
    stall_due  = now_r > next_stall;
  end

  // history log requests
  always_comb begin
    hist_log = '{en: 1'b0, status: obpc_pkg::ST_PERIOD, period: 16'd0};
    if (state == S_DETECT) begin
      if (det_long) begin
        hist_log = '{en: 1'b1, status: obpc_pkg::ST_LONG, period: 16'd0};
      end else if (det_settle && !det_big) begin
        hist_log = '{en: 1'b1, status: obpc_pkg::ST_SMALL, period: 16'd0};
      end else if (det_settle && (gap > obpc_pkg::STALL_MS)) begin
        hist_log = '{en: 1'b1, status: obpc_pkg::ST_STALL, period: 16'd0};
      end else if (det_settle) begin
        hist_log = '{en: 1'b1, status: obpc_pkg::ST_PERIOD, period: obpc_pkg::sat16(per)};
      end
    end else if (state == S_STALL && stall_due && run_gap > obpc_pkg::STALL_MS) begin
      hist_log = '{en: 1'b1, status: obpc_pkg::ST_STALL, period: 16'd0};
    end
  end

  assign scan_start = (state == S_SECOND) && logged;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b1;
      change_level     <= 10'd20;
      change_time      <= 8'd50;
      max_bubble_ms    <= 8'd200;
      min_bubble_level <= 8'd50;
      minmax_period    <= 16'd250;
    end else if (cfg_we) begin
      unique case (cfg_index)
        obpc_pkg::CFG_ENABLE:        enable           <= cfg_data[0];
        obpc_pkg::CFG_CHANGE_LEVEL:  change_level     <= cfg_data[9:0];
        obpc_pkg::CFG_CHANGE_TIME:   change_time      <= cfg_data[7:0];
        obpc_pkg::CFG_MAX_BUBBLE_MS: max_bubble_ms    <= cfg_data[7:0];
        obpc_pkg::CFG_MIN_BUBBLE_LV: min_bubble_level <= cfg_data[7:0];
        obpc_pkg::CFG_MINMAX_PERIOD: minmax_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and all per-sample state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_IDLE;
      primed       <= 1'b0;
      prev_time    <= '0;
      prev_level   <= '0;
      head         <= '0;
      tail         <= '0;
      window_time  <= '0;
      window_level <= '0;
      run_ms       <= '0;
      run_lvl      <= '0;
      peak_lvl     <= '0;
      run_gap      <= '0;
      count        <= '0;
      next_minmax  <= '0;
      next_stall   <= '0;
      next_second  <= '0;
      run_min      <= obpc_pkg::LEVEL_MAX;
      run_max      <= '0;
      rep_min      <= '0;
      rep_max      <= '0;
      rep_bubble   <= '0;
      rep_gap      <= '0;
      cnt_samples  <= '0;
      cnt_werr     <= '0;
      cnt_oerr     <= '0;
      rep_samples  <= '0;
      rep_werr     <= '0;
      rep_oerr     <= '0;
      flags        <= '0;
      logged       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (hist_log.en) begin
        flags[obpc_pkg::FL_LOGGED] <= 1'b1;
        logged                     <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            now_r <= sample.payload.now_ms;
            lvl_r <= sample.payload.level;
            if (!enable) begin
              state <= S_DONE;
            end else if (!primed) begin
              primed     <= 1'b1;
              prev_time  <= sample.payload.now_ms;
              prev_level <= sample.payload.level;
              state      <= S_DONE;
            end else if (sample.payload.now_ms == prev_time) begin
              state <= S_DONE;
            end else begin
              state <= S_FRONT;
            end
          end
        end
        S_FRONT: begin
          if (now_r > next_minmax) begin
            next_minmax <= now_r + 32'(minmax_period);
            rep_min     <= mn_n;
            rep_max     <= mx_n;
            run_min     <= obpc_pkg::LEVEL_MAX;
            run_max     <= '0;
            flags[obpc_pkg::FL_MINMAX] <= 1'b1;
          end else begin
            run_min <= mn_n;
            run_max <= mx_n;
          end
          dtb_r        <= dtb;
          dlb_r        <= dlb;
          window_time  <= window_time + WT_W'(dtb);
          window_level <= window_level + WL_W'(obpc_pkg::level_delta(dlb));
          run_gap      <= gap_sum[32] ? 32'hFFFF_FFFF : gap_sum[31:0];
          state        <= S_SHRINK;
        end
        S_SHRINK: begin
          state <= shrink_go ? S_SHRINK_RD : S_DETECT;
        end
        S_SHRINK_RD: begin
          window_time  <= window_time - WT_W'(ring_rdata[15:8]);
          window_level <= window_level - WL_W'(obpc_pkg::level_delta(ring_rdata[7:0]));
          tail         <= tail_next;
          state        <= S_SHRINK;
        end
        S_DETECT: begin
          if (win_over) begin
            cnt_werr <= obpc_pkg::inc16(cnt_werr);
          end
          if (phase == PH_IDLE) begin
            if (det_rise) begin
              phase    <= PH_RISE;
              run_ms   <= 16'(window_time);
              run_lvl  <= RL_W'(window_level);
              peak_lvl <= RL_W'(window_level);
              flags[obpc_pkg::FL_LIGHT_ON] <= 1'b1;
            end
          end else if (det_long || det_settle) begin
            // bubble ends: counted one updates the reports
            if (det_settle && det_big) begin
              rep_bubble <= rbm_n;
              rep_gap    <= obpc_pkg::sat16(gap);
              run_gap    <= '0;
              count      <= count + 32'd1;
              next_stall <= now_r + obpc_pkg::STALL_MS;
            end
            run_ms   <= '0;
            run_lvl  <= '0;
            peak_lvl <= '0;
            phase    <= PH_IDLE;
            flags[obpc_pkg::FL_LIGHT_OFF] <= 1'b1;
          end else begin
            run_ms   <= rbm_n;
            run_lvl  <= rbl_n;
            peak_lvl <= peak_n;
            if (det_fall) begin
              phase <= PH_FALL;
            end
          end
          state <= S_ADV;
        end
        S_ADV: begin
          head <= head_next;
          if (head_next == tail) begin
            cnt_oerr <= obpc_pkg::inc16(cnt_oerr);
            state    <= S_OVF_RD;
          end else begin
            state <= S_STALL;
          end
        end
        S_OVF_RD: begin
          window_time  <= window_time - WT_W'(ring_rdata[15:8]);
          window_level <= window_level - WL_W'(obpc_pkg::level_delta(ring_rdata[7:0]));
          tail         <= tail_next;
          state        <= S_STALL;
        end
        S_STALL: begin
          if (stall_due) begin
            next_stall <= now_r + obpc_pkg::STALL_MS;
          end
          state <= S_SECOND;
        end
        S_SECOND: begin
          prev_time  <= now_r;
          prev_level <= lvl_r;
          if (now_r > next_second) begin
            next_second <= next_second + obpc_pkg::SECOND_MS;
            rep_samples <= cnt_samples;
            rep_werr    <= cnt_werr;
            rep_oerr    <= cnt_oerr;
            cnt_samples <= '0;
            cnt_werr    <= '0;
            cnt_oerr    <= '0;
            flags[obpc_pkg::FL_SECOND] <= 1'b1;
          end else begin
            cnt_samples <= obpc_pkg::inc16(cnt_samples);
          end
          state <= logged ? S_SCAN_WAIT : S_DONE;
        end
        S_SCAN_WAIT: begin
          if (!hist_view.busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_reg <= '{event_flags: flags, bubble_count: count,
                         period_status: hist_view.status, period_ms: hist_view.period,
                         regular: hist_view.regular, min_seen: rep_min, max_seen: rep_max,
                         bubble_ms: rep_bubble, gap_ms: rep_gap,
                         samples_per_sec: rep_samples, window_errors_per_sec: rep_werr,
                         overflow_errors_per_sec: rep_oerr};
            out_valid <= 1'b1;
            flags     <= '0;
            logged    <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sample.ready   = (state == S_IDLE);
  assign result.valid   = out_valid;
  assign result.payload = out_reg;

`ifndef ASSERT_OFF
  // after the overflow drop the ring is never empty-equal
  a_ring_apart: assert property (@(posedge clk) disable iff (rst)
    state == S_STALL |-> head != tail)
    else $error("ring head meets tail after advance");

  // trimming leaves the window within span or down to one entry
  a_window_trimmed: assert property (@(posedge clk) disable iff (rst)
    state == S_DETECT |-> (!win_over || tail == head))
    else $error("window not trimmed before detection");

  // the history scan runs only while the sequencer waits on it
  a_scan_owned: assert property (@(posedge clk) disable iff (rst)
    hist_view.busy |-> state == S_SCAN_WAIT)
    else $error("history scan outside its wait state");

  // once primed the block stays primed until reset
  a_primed_holds: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed dropped without reset");
`endif
endmodule

// ===== test/optical_bubble_pulse_counter_tb.sv =====
// self-checking testbench for the optical bubble pulse counter
module optical_bubble_pulse_counter_tb;

  localparam int RING_DEPTH = 64;
  localparam int LOG_DEPTH = 8;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = obpc_pkg::CFG_ENABLE;
  logic [15:0] cfg_data = '0;

  obpc_sample_if sample ();
  obpc_result_if result ();

  optical_bubble_pulse_counter dut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic en_q;
  logic [9:0] chg_level_q;
  logic [7:0] chg_time_q, max_bub_q, min_bub_q;
  logic [15:0] mm_period_q;
  logic [7:0] dt_ring [RING_DEPTH];
  logic [7:0] dl_ring [RING_DEPTH];
  int unsigned head_q, tail_q, win_time;
  int win_level;
  int unsigned phase_q, bub_ms;
  int bub_level, bub_peak;
  logic [31:0] gap_acc, count_q;
  logic [1:0] log_status [LOG_DEPTH];
  logic [15:0] log_period [LOG_DEPTH];
  int unsigned log_idx;
  bit primed_q;
  logic [31:0] last_time, next_mm, next_stall, next_sec;
  logic [9:0] last_level, run_min, run_max, rep_min, rep_max;
  logic [15:0] rep_bub, rep_gap, cnt_smp, cnt_werr, cnt_oerr, rep_smp, rep_werr, rep_oerr;

  obpc_pkg::result_t expected_results [$];
  obpc_pkg::sample_t pending_samples [$];
  bit failed = 1'b0;

  function automatic logic [15:0] sat_16(logic [31:0] v);
    return v > 32'hFFFF ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] bump_16(logic [15:0] v);
    return v == 16'hFFFF ? v : v + 16'd1;
  endfunction

  task automatic reset_counter_model();
    en_q = 1; chg_level_q = 20; chg_time_q = 50; max_bub_q = 200; min_bub_q = 50;
    mm_period_q = 250;
    for (int i = 0; i < RING_DEPTH; i++) begin
      dt_ring[i] = 0; dl_ring[i] = 125;
    end
    head_q = 0; tail_q = 0; win_time = 0; win_level = 0;
    phase_q = 0; bub_ms = 0; bub_level = 0; bub_peak = 0; gap_acc = 0; count_q = 0;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      log_status[i] = obpc_pkg::ST_LONG; log_period[i] = 0;
    end
    log_idx = 0; primed_q = 0; last_time = 0; last_level = 0;
    next_mm = 0; next_stall = 0; next_sec = 0; run_min = obpc_pkg::LEVEL_MAX; run_max = 0;
    rep_min = 0; rep_max = 0; rep_bub = 0; rep_gap = 0;
    cnt_smp = 0; cnt_werr = 0; cnt_oerr = 0; rep_smp = 0; rep_werr = 0; rep_oerr = 0;
  endtask

  task automatic write_cfg_model(logic [2:0] idx, logic [15:0] v);
    case (idx)
      obpc_pkg::CFG_ENABLE: en_q = v[0];
      obpc_pkg::CFG_CHANGE_LEVEL: chg_level_q = v[9:0];
      obpc_pkg::CFG_CHANGE_TIME: chg_time_q = v[7:0];
      obpc_pkg::CFG_MAX_BUBBLE_MS: max_bub_q = v[7:0];
      obpc_pkg::CFG_MIN_BUBBLE_LV: min_bub_q = v[7:0];
      obpc_pkg::CFG_MINMAX_PERIOD: mm_period_q = v;
      default: ;
    endcase
  endtask

  task automatic log_duration(logic [1:0] st, logic [31:0] per, inout logic [4:0] fl);
    fl[obpc_pkg::FL_LOGGED] = 1'b1;
    log_idx = (log_idx + 1) % LOG_DEPTH;
    log_status[log_idx] = st;
    log_period[log_idx] = (st == obpc_pkg::ST_PERIOD) ? sat_16(per) : 16'd0;
  endtask

  task automatic close_bubble(inout logic [4:0] fl);
    bub_ms = 0; bub_level = 0; bub_peak = 0; phase_q = 0;
    fl[obpc_pkg::FL_LIGHT_OFF] = 1'b1;
  endtask

  task automatic drop_ring_tail();
    win_time -= dt_ring[tail_q];
    win_level -= int'(dl_ring[tail_q]) - 125;
    tail_q = (tail_q + 1) % RING_DEPTH;
  endtask

  function automatic logic history_regular();
    bit all_stall;
    int unsigned lo, hi, tol;
    all_stall = 1; lo = 65535; hi = 0;
    for (int i = 0; i < LOG_DEPTH; i++)
      if (log_status[i] != obpc_pkg::ST_STALL) all_stall = 0;
    if (all_stall) return 1'b1;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      if (log_status[i] != obpc_pkg::ST_PERIOD) return 1'b0;
      if (log_period[i] < lo) lo = log_period[i];
      if (log_period[i] > hi) hi = log_period[i];
    end
    tol = lo > 5000 ? 20 : 10;
    return (lo + tol <= hi) ? 1'b0 : 1'b1;
  endfunction

  // advance the bubble counter model by one sample
  task automatic predict_sample(obpc_pkg::sample_t s);
    logic [4:0] fl;
    logic [31:0] now, dt, gap;
    int dl, cl;
    logic [7:0] dtb, dlb;
    obpc_pkg::result_t r;
    fl = '0; now = s.now_ms;
    if (en_q && !primed_q) begin
      primed_q = 1; last_time = now; last_level = s.level;
    end else if (en_q && now != last_time) begin
      dt = now - last_time;
      dl = int'(s.level) - int'(last_level) + 125;
      cl = int'(chg_level_q);
      if (s.level < run_min) run_min = s.level;
      if (s.level > run_max) run_max = s.level;
      if (now > next_mm) begin
        next_mm = now + mm_period_q;
        rep_min = run_min; rep_max = run_max; run_min = obpc_pkg::LEVEL_MAX; run_max = 0;
        fl[obpc_pkg::FL_MINMAX] = 1'b1;
      end
      dtb = dt > 255 ? 8'd255 : dt[7:0];
      dlb = dl < 0 ? 8'd0 : (dl > 255 ? 8'd255 : 8'(dl));
      dt_ring[head_q] = dtb; dl_ring[head_q] = dlb;
      win_time += dtb; win_level += int'(dlb) - 125;
      gap_acc = (gap_acc > 32'hFFFFFFFF - dtb) ? 32'hFFFFFFFF : gap_acc + dtb;
      while (win_time > chg_time_q && tail_q != head_q) drop_ring_tail();
      if (win_time > chg_time_q) cnt_werr = bump_16(cnt_werr);
      if (phase_q == 0) begin
        if (win_level > cl) begin
          phase_q = 1; bub_ms = win_time; bub_level = win_level; bub_peak = win_level;
          fl[obpc_pkg::FL_LIGHT_ON] = 1'b1;
        end
      end else begin
        bub_ms += dtb;
        bub_level += int'(dlb) - 125;
        if (bub_level > bub_peak) bub_peak = bub_level;
        if (bub_ms > max_bub_q) begin
          log_duration(obpc_pkg::ST_LONG, 0, fl);
          close_bubble(fl);
        end else if (phase_q == 1 && win_level < -cl) begin
          phase_q = 2;
        end else if (phase_q == 2 && win_level >= -cl && win_level <= cl) begin
          if (bub_peak > int'(min_bub_q)) begin
            gap = gap_acc > bub_ms ? gap_acc - bub_ms : 32'd0;
            rep_bub = sat_16(bub_ms); rep_gap = sat_16(gap);
            gap_acc = 0; count_q++;
            next_stall = now + 32'd10000;
            if (gap > 10000) log_duration(obpc_pkg::ST_STALL, 0, fl);
            else log_duration(obpc_pkg::ST_PERIOD, bub_ms + gap, fl);
          end else begin
            log_duration(obpc_pkg::ST_SMALL, 0, fl);
          end
          close_bubble(fl);
        end
      end
      head_q = (head_q + 1) % RING_DEPTH;
      if (head_q == tail_q) begin
        cnt_oerr = bump_16(cnt_oerr);
        drop_ring_tail();
      end
      if (now > next_stall) begin
        next_stall = now + 32'd10000;
        if (gap_acc > 10000) log_duration(obpc_pkg::ST_STALL, 0, fl);
      end
      last_time = now; last_level = s.level;
      if (now > next_sec) begin
        next_sec += 32'd1000;
        rep_smp = cnt_smp; rep_werr = cnt_werr; rep_oerr = cnt_oerr;
        cnt_smp = 0; cnt_werr = 0; cnt_oerr = 0;
        fl[obpc_pkg::FL_SECOND] = 1'b1;
      end else begin
        cnt_smp = bump_16(cnt_smp);
      end
    end
    r.event_flags = fl; r.bubble_count = count_q;
    r.period_status = log_status[log_idx]; r.period_ms = log_period[log_idx];
    r.regular = history_regular();
    r.min_seen = rep_min; r.max_seen = rep_max; r.bubble_ms = rep_bub; r.gap_ms = rep_gap;
    r.samples_per_sec = rep_smp; r.window_errors_per_sec = rep_werr;
    r.overflow_errors_per_sec = rep_oerr;
    expected_results.push_back(r);
  endtask

  // sample driver
  int send_wait = 0;
  bit in_taken = 1'b0;
  initial begin
    sample.valid = 1'b0;
    sample.payload = '0;
  end
  // transaction accepted at this rising edge
  always @(posedge clk) begin
    in_taken = !rst && sample.valid && sample.ready;
  end
  always @(negedge clk) begin
    if (in_taken) begin
      predict_sample(sample.payload);
      send_wait = $urandom_range(0, 3);
      in_taken = 1'b0;
    end
    if (rst || (sample.valid && !sample.ready)) begin
      // hold
    end else if (send_wait > 0 || pending_samples.size() == 0) begin
      if (send_wait > 0) send_wait--;
      sample.valid <= 1'b0;
    end else begin
      sample.payload <= pending_samples.pop_front();
      sample.valid <= 1'b1;
    end
  end

  // result monitor
  int recv_wait = 0;
  int idle_cycles = 0;
  initial result.ready = 1'b0;
  always @(negedge clk) begin
    if (recv_wait > 0) begin
      recv_wait--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result.payload);
        failed = 1'b1;
      end else begin
        obpc_pkg::result_t e;
        e = expected_results.pop_front();
        if (e !== result.payload)
          $display("%0t: result mismatch expected %p actual %p", $time, e, result.payload);
        if (e !== result.payload) failed = 1'b1;
      end
      recv_wait = $urandom_range(0, 3);
      if ($urandom_range(0, 9) < 3) recv_wait = 0;
    end
    // watchdog
    if ((sample.valid && sample.ready) || (result.valid && result.ready) || rst ||
        (pending_samples.size() == 0 && expected_results.size() == 0 && !sample.valid))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("optical_bubble_pulse_counter_tb failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_samples.size() != 0 || sample.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] v);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = v;
    write_cfg_model(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic push_sample(logic [31:0] t, logic [9:0] lv);
    obpc_pkg::sample_t s;
    s.now_ms = t; s.level = lv;
    pending_samples.push_back(s);
  endtask

  // a bubble shaped pulse: rise, plateau, fall, settle
  task automatic push_bubble(inout logic [31:0] t, input int base, input int amp, input int w);
    for (int i = 0; i < w; i++) begin
      t += $urandom_range(1, 3);
      push_sample(t, 10'(base + amp * (i < w / 2 ? i + 1 : w - i) / (w / 2)));
    end
    for (int i = 0; i < 6; i++) begin
      t += $urandom_range(1, 4);
      push_sample(t, 10'(base + $urandom_range(0, 3)));
    end
  endtask

  logic [31:0] clock_ms;
  initial begin
    reset_counter_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: priming, repeats, extremes, backward time, big jumps
    clock_ms = 32'd5;
    push_sample(clock_ms, 10'd0);
    push_sample(clock_ms, 10'd1023);
    push_sample(clock_ms + 1, 10'd1023);
    push_sample(clock_ms + 2, 10'd0);
    push_sample(clock_ms + 3, 10'd1023);
    push_sample(clock_ms + 4, 10'd0);
    push_sample(clock_ms + 3000, 10'd512);
    push_sample(clock_ms + 2990, 10'd300);
    push_sample(32'hFFFF_FFF0, 10'd700);
    push_sample(32'hFFFF_FFFF, 10'd10);
    push_sample(32'd0, 10'd600);
    push_sample(32'd2, 10'd600);
    clock_ms = 32'd40000;
    push_bubble(clock_ms, 100, 400, 8);
    drain();

    // disabled samples leave state untouched
    write_cfg(obpc_pkg::CFG_ENABLE, 16'd0);
    push_sample(clock_ms + 10, 10'd900);
    push_sample(clock_ms + 20, 10'd5);
    drain();
    write_cfg(obpc_pkg::CFG_ENABLE, 16'hFFFF);

    // several settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_cfg(obpc_pkg::CFG_CHANGE_LEVEL, 16'd1023);
          write_cfg(obpc_pkg::CFG_CHANGE_TIME, 16'd1);
          write_cfg(obpc_pkg::CFG_MAX_BUBBLE_MS, 16'd0);
          write_cfg(obpc_pkg::CFG_MIN_BUBBLE_LV, 16'd0);
          write_cfg(obpc_pkg::CFG_MINMAX_PERIOD, 16'd1);
        end
        1: begin
          write_cfg(obpc_pkg::CFG_CHANGE_LEVEL, 16'd0);
          write_cfg(obpc_pkg::CFG_CHANGE_TIME, 16'd255);
          write_cfg(obpc_pkg::CFG_MAX_BUBBLE_MS, 16'd255);
          write_cfg(obpc_pkg::CFG_MIN_BUBBLE_LV, 16'd255);
          write_cfg(obpc_pkg::CFG_MINMAX_PERIOD, 16'hFFFF);
        end
        default: begin
          write_cfg(obpc_pkg::CFG_CHANGE_LEVEL, 16'($urandom_range(5, 60)));
          write_cfg(obpc_pkg::CFG_CHANGE_TIME, 16'($urandom_range(10, 120)));
          write_cfg(obpc_pkg::CFG_MAX_BUBBLE_MS, 16'($urandom_range(40, 255)));
          write_cfg(obpc_pkg::CFG_MIN_BUBBLE_LV, 16'($urandom_range(0, 120)));
          write_cfg(obpc_pkg::CFG_MINMAX_PERIOD, 16'($urandom_range(1, 600)));
        end
      endcase
      for (int n = 0; n < 6; n++) begin
        case ($urandom_range(0, 9))
          0: begin
            // noise: random jumps, repeats and backward time
            for (int k = 0; k < 6; k++) begin
              clock_ms += $urandom_range(0, 2) == 0 ? -$urandom_range(0, 5) : $urandom;
              push_sample(clock_ms, 10'($urandom));
            end
          end
          1: begin
            // long quiet stretch to cause stalls and ring overflow
            for (int k = 0; k < 70; k++) begin
              clock_ms += $urandom_range(1, 2);
              push_sample(clock_ms, 10'($urandom_range(0, 2)));
            end
            clock_ms += $urandom_range(9000, 15000);
            push_sample(clock_ms, 10'($urandom));
          end
          default: push_bubble(clock_ms, $urandom_range(0, 400), $urandom_range(10, 600),
                               2 * $urandom_range(2, 6));
        endcase
      end
      drain();
    end
    if (!failed) begin
      $display("optical_bubble_pulse_counter_tb passed");
    end else begin
      $display("optical_bubble_pulse_counter_tb failed");
    end
    $finish;
  end

  initial begin
    cfg_we = 1'b0;
  end

endmodule

// ===== files.f =====
design/obpc_pkg.sv
design/obpc_sample_if.sv
design/obpc_result_if.sv
design/obpc_ram.sv
design/obpc_history.sv
design/optical_bubble_pulse_counter.sv
test/optical_bubble_pulse_counter_tb.sv
